// ----- rtl/zero_run_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// zero_run_encoder_defines.svh
// Assertion macros shared by the zero-run encoder modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_ENCODER_DEFINES_SVH
`define ZERO_RUN_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZRE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/zre_pkg.sv -----
// ----------------------------------------------------------------------------
// zre_pkg
// Types and constants shared by the zero-run encoder modules.
// ----------------------------------------------------------------------------
package zre_pkg;

    localparam logic [15:0] FULL_COUNT     = 16'hffff;
    localparam logic [7:0]  ZERO_BYTE      = 8'h00;
    localparam logic [7:0]  ALL_ONES_BYTE  = 8'hff;
    localparam int          ZRE_QUEUE_DEPTH = 2;

    // One command covers every byte that a single input item produces:
    // an optional count flush, an optional body byte and an optional
    // trailing zero count.
    typedef struct packed {
        logic        pre;
        logic [15:0] pre_count;
        logic        body;
        logic [7:0]  body_byte;
        logic        post;
        logic        last;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_PRE_LO,
        PH_PRE_HI,
        PH_BODY,
        PH_POST_LO,
        PH_POST_HI
    } phase_t;

endpackage

// ----- rtl/zre_in_if.sv -----
// ----------------------------------------------------------------------------
// zre_in_if
// Raw byte channel into the zero-run encoder.
// ----------------------------------------------------------------------------
interface zre_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       end_of_buffer;

    modport source (output valid, output raw_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input raw_byte, input end_of_buffer, output ready);

endinterface

// ----- rtl/zre_out_if.sv -----
// ----------------------------------------------------------------------------
// zre_out_if
// Coded byte channel out of the zero-run encoder.
// ----------------------------------------------------------------------------
interface zre_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;
    logic       final_byte;

    modport source (output valid, output coded_byte, output final_byte, input ready);
    modport sink   (input valid, input coded_byte, input final_byte, output ready);

endinterface

// ----- rtl/zre_front.sv -----
// ----------------------------------------------------------------------------
// zre_front
// Accepts raw bytes, tracks the open zero run and its count, and turns each
// request that yields coded bytes into one command for the output sequencer.
// ----------------------------------------------------------------------------
module zre_front
    import zre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    zre_in_if.sink    in_bytes,
    input  logic      q_ready,
    output logic      push,
    output cmd_t      push_cmd
);

    logic        run_open_reg;
    logic        run_open_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        accept;
    logic        produce;
    logic [15:0] count_inc;

    assign in_bytes.ready = q_ready;
    assign accept         = in_bytes.valid && q_ready;
    assign count_inc      = count_reg + 16'd1;
    assign push           = accept && produce;

    always_comb
    begin
        push_cmd           = '0;
        push_cmd.last      = in_bytes.end_of_buffer;
        produce            = 1'b1;
        run_open_next      = run_open_reg;
        count_next         = count_reg;
        if (in_bytes.raw_byte == ZERO_BYTE)
        begin
            if (!run_open_reg)
            begin
                push_cmd.body      = 1'b1;
                push_cmd.body_byte = ZERO_BYTE;
                push_cmd.post      = in_bytes.end_of_buffer;
                run_open_next      = 1'b1;
                count_next         = '0;
            end
            else if (count_reg == FULL_COUNT)
            begin
                push_cmd.pre       = 1'b1;
                push_cmd.pre_count = FULL_COUNT;
                push_cmd.body      = 1'b1;
                push_cmd.body_byte = ZERO_BYTE;
                push_cmd.post      = in_bytes.end_of_buffer;
                count_next         = '0;
            end
            else
            begin
                count_next = count_inc;
                if (in_bytes.end_of_buffer)
                begin
                    push_cmd.pre       = 1'b1;
                    push_cmd.pre_count = count_inc;
                end
                else
                begin
                    produce = 1'b0;
                end
            end
            if (in_bytes.end_of_buffer)
            begin
                run_open_next = 1'b0;
                count_next    = '0;
            end
        end
        else
        begin
            if (run_open_reg)
            begin
                push_cmd.pre       = 1'b1;
                push_cmd.pre_count = count_reg;
            end
            push_cmd.body      = 1'b1;
            push_cmd.body_byte = in_bytes.raw_byte;
            run_open_next      = 1'b0;
            count_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            count_reg    <= '0;
        end
        else if (accept)
        begin
            run_open_reg <= run_open_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ----- rtl/zre_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// zre_cmd_queue
// Short command queue between the front and the output sequencer.
// ----------------------------------------------------------------------------
`include "zero_run_encoder_defines.svh"

module zre_cmd_queue
    import zre_pkg::*;
#(
    parameter int DEPTH = ZRE_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic ready,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign ready      = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ZRE_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= CW'(DEPTH), "queue count exceeds depth")
    `ZRE_ASSERT_SAME(a_no_push_full, push, count_reg != CW'(DEPTH), "push into a full queue")
    `ZRE_ASSERT_SAME(a_no_pop_empty, pop, count_reg != '0, "pop from an empty queue")

endmodule

// ----- rtl/zre_back.sv -----
// ----------------------------------------------------------------------------
// zre_back
// Output sequencer: expands the command at the queue head into coded bytes,
// one per cycle unless the receiver stalls, into the output register.
// ----------------------------------------------------------------------------
`include "zero_run_encoder_defines.svh"

module zre_back
    import zre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head_cmd,
    output logic      pop,
    zre_out_if.source out_bytes
);

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     cur_phase;
    phase_t     after_phase;
    logic       cmd_done;
    logic       advance;
    logic [7:0] cur_byte;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_final_reg;

    assign advance = head_valid && (!out_valid_reg || out_bytes.ready);
    assign pop     = advance && cmd_done;

    always_comb
    begin
        if (phase_reg != PH_START)
        begin
            cur_phase = phase_reg;
        end
        else if (head_cmd.pre)
        begin
            cur_phase = PH_PRE_LO;
        end
        else if (head_cmd.body)
        begin
            cur_phase = PH_BODY;
        end
        else
        begin
            cur_phase = PH_POST_LO;
        end
    end

    // Next state: step through the parts the command holds.
    always_comb
    begin
        after_phase = PH_START;
        unique case (cur_phase)
            PH_PRE_LO:  after_phase = PH_PRE_HI;
            PH_PRE_HI:  after_phase = head_cmd.body ? PH_BODY :
                                      (head_cmd.post ? PH_POST_LO : PH_START);
            PH_BODY:    after_phase = head_cmd.post ? PH_POST_LO : PH_START;
            PH_POST_LO: after_phase = PH_POST_HI;
            PH_POST_HI: after_phase = PH_START;
            default:    after_phase = PH_START;
        endcase
        phase_next = advance ? after_phase : phase_reg;
    end

    // Outputs of the sequencer: the byte of the current part.
    always_comb
    begin
        cur_byte = ZERO_BYTE;
        unique case (cur_phase)
            PH_PRE_LO:               cur_byte = head_cmd.pre_count[7:0];
            PH_PRE_HI:               cur_byte = head_cmd.pre_count[15:8];
            PH_BODY:                 cur_byte = head_cmd.body_byte;
            PH_POST_LO, PH_POST_HI:  cur_byte = ZERO_BYTE;
            default:                 cur_byte = ZERO_BYTE;
        endcase
        cmd_done = (after_phase == PH_START);
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_bytes.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= cur_byte;
            out_final_reg <= head_cmd.last && cmd_done;
        end
    end

    assign out_bytes.valid      = out_valid_reg;
    assign out_bytes.coded_byte = out_byte_reg;
    assign out_bytes.final_byte = out_final_reg;

    `ZRE_ASSERT_SAME(a_mid_cmd_has_head, phase_reg != PH_START, head_valid,
                     "command vanished while being expanded")
    `ZRE_ASSERT_SAME(a_pop_on_advance, pop, advance, "command popped without output")
    `ZRE_ASSERT_NEXT(a_phase_holds, (phase_reg != PH_START) && !advance, $stable(phase_reg),
                     "sequencer moved while stalled")

endmodule

// ----- rtl/zero_run_encoder.sv -----
// ----------------------------------------------------------------------------
// zero_run_encoder
// Streaming zero-run encoder. The first zero of a run is passed through and
// followed by a 16-bit little-endian count of the zeros after it; a nonzero
// byte or the end of the buffer flushes the count, and a full count emits
// FF FF and a fresh literal zero.
//
// Channels: in_bytes carries raw_byte and end_of_buffer, out_bytes carries
// coded_byte and final_byte; both move a request when valid and ready are
// high at a rising clock edge.
// A request is registered into the command queue, and its first coded byte
// is then registered into the output register.
// Throughput: one coded byte per cycle while ready is high. A request yields
// zero to five coded bytes and a plain byte one, so plain bytes flow at one
// per cycle; the output sequencer, emitting one byte a cycle, sets the rate.
// Reset: clears the run state, the command queue and the output valid flag.
// Stall: when the receiver holds ready low, the output byte holds, the
// command queue fills, and in_bytes.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module zero_run_encoder
    import zre_pkg::*;
#(
    parameter int QUEUE_DEPTH = ZRE_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    zre_in_if.sink    in_bytes,
    zre_out_if.source out_bytes
);

    logic q_ready;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    zre_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bytes (in_bytes),
        .q_ready  (q_ready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    zre_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    zre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_bytes  (out_bytes)
    );

endmodule

// ----- test/zre_stream_checker.sv -----
// ----------------------------------------------------------------------------
// zre_stream_checker
// Watches both channels of the zero-run encoder. It computes the coded bytes
// that each accepted raw byte should produce, compares every accepted coded
// byte with the oldest one still owed, and reports the running mismatch count
// and the number of coded bytes still outstanding.
// ----------------------------------------------------------------------------
module zre_stream_checker
    import zre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    zre_in_if    in_bytes,
    zre_out_if   out_bytes,
    output int   mismatches,
    output int   pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } coded_t;

    coded_t      coded_expected[$];
    logic        run_open    = 1'b0;
    logic [15:0] extra_zeros = 16'h0000;
    int          fail_count  = 0;
    int          out_index   = 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch at coded byte %0d: %s", $time, out_index, what);
    endtask

    task automatic push_coded(input logic [7:0] value);
        coded_t item;
        item           = coded_t'{value: value, last: 1'b0};
        coded_expected = {coded_expected, item};
    endtask

    task automatic flush_count();
        push_coded(extra_zeros[7:0]);
        push_coded(extra_zeros[15:8]);
        run_open    = 1'b0;
        extra_zeros = 16'h0000;
    endtask

    task automatic encode_raw(input logic [7:0] raw, input logic mark_end);
        int before_size;
        before_size = coded_expected.size();
        if (raw == ZERO_BYTE) begin
            if (!run_open) begin
                push_coded(ZERO_BYTE);
                run_open    = 1'b1;
                extra_zeros = 16'h0000;
            end
            else if (extra_zeros == FULL_COUNT) begin
                push_coded(ALL_ONES_BYTE);
                push_coded(ALL_ONES_BYTE);
                push_coded(ZERO_BYTE);
                extra_zeros = 16'h0000;
            end
            else begin
                extra_zeros = extra_zeros + 16'd1;
            end
            if (mark_end)
            begin
                flush_count();
            end
        end
        else begin
            if (run_open)
            begin
                flush_count();
            end
            push_coded(raw);
        end
        if (mark_end && coded_expected.size() > before_size) begin
            coded_expected[coded_expected.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_coded(input logic [7:0] value, input logic last);
        coded_t want;
        if (coded_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected coded byte %02h final %0b", value, last));
        end
        else begin
            want = coded_expected.pop_front();
            if (value !== want.value)
            begin
                report_mismatch($sformatf("coded_byte %02h, expected %02h",
                                          value, want.value));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("final_byte %0b, expected %0b", last, want.last));
            end
        end
        out_index++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            run_open    = 1'b0;
            extra_zeros = 16'h0000;
            coded_expected.delete();
        end
        else begin
            if (in_bytes.valid && in_bytes.ready)
            begin
                encode_raw(in_bytes.raw_byte, in_bytes.end_of_buffer);
            end
            if (out_bytes.valid && out_bytes.ready)
            begin
                check_coded(out_bytes.coded_byte, out_bytes.final_byte);
            end
        end
        mismatches <= fail_count;
        pending    <= coded_expected.size();
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the zero-run encoder. Directed buffers cover plain
// bytes, short zero runs and runs closed by a nonzero byte or buffer end, then
// random buffers rich in zeros follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import zre_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic steady = 1'b0;
    int   mismatches;
    int   pending;

    zre_in_if  raw_ch();
    zre_out_if coded_ch();

    zero_run_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_bytes  (raw_ch),
        .out_bytes (coded_ch)
    );

    zre_stream_checker stream_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_bytes   (raw_ch),
        .out_bytes  (coded_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        coded_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            coded_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
        end
    end

    task automatic send_raw(input logic [7:0] raw, input logic mark_end);
        while (!steady && $urandom_range(0, 99) < 30) begin
            raw_ch.valid <= 1'b0;
            @(posedge clk);
        end
        raw_ch.valid         <= 1'b1;
        raw_ch.raw_byte      <= raw;
        raw_ch.end_of_buffer <= mark_end;
        @(posedge clk);
        while (!raw_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_zeros(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_raw(ZERO_BYTE, 1'b0);
        end
    endtask

    task automatic wait_drained();
        raw_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial begin
        int         pick;
        logic [7:0] raw;
        rst_n                <= 1'b0;
        raw_ch.valid         <= 1'b0;
        raw_ch.raw_byte      <= 8'h00;
        raw_ch.end_of_buffer <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_raw(8'h5a, 1'b1);
        send_raw(ZERO_BYTE, 1'b1);
        send_zeros(3);
        send_raw(8'h07, 1'b0);
        send_raw(ALL_ONES_BYTE, 1'b1);
        send_raw(ZERO_BYTE, 1'b0);
        send_raw(8'h80, 1'b1);
        send_raw(8'h01, 1'b0);
        send_raw(ZERO_BYTE, 1'b0);
        send_raw(ZERO_BYTE, 1'b1);
        send_zeros(2);
        send_raw(ZERO_BYTE, 1'b1);

        wait_drained();

        for (int i = 0; i < 250; i++) begin
            if (i == 100)
            begin
                steady <= 1'b1;
            end
            if (i == 160)
            begin
                steady <= 1'b0;
            end
            if (i == 200)
            begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                raw = ZERO_BYTE;
            end
            else if (pick < 55)
            begin
                raw = ALL_ONES_BYTE;
            end
            else
            begin
                raw = 8'($urandom_range(1, 255));
            end
            send_raw(raw, ($urandom_range(0, 7) == 0) || (i == 249));
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
